// ===== sv/cmu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cmu_pkg
// Shared constants and types of the complex magnitude unit.
// ----------------------------------------------------------------------------
package cmu_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int MAG_WIDTH        = 16;
	localparam int POWER_WIDTH      = 32;

	// Side data that travels with a word through the root pipeline.
	typedef struct packed {
		logic                   valid;
		logic                   last;
		logic [POWER_WIDTH-1:0] power;
	} side_t;

endpackage
`default_nettype wire

// ===== sv/cmu_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cmu_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module cmu_isqrt #(
	parameter int RAD_WIDTH = 2 * cmu_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic [RAD_WIDTH-1:0] rad,
	input  wire cmu_pkg::side_t       side,
	output logic      [RAD_WIDTH-1:0] root,
	output cmu_pkg::side_t            side_out
);

	localparam int STAGES = RAD_WIDTH / 2;

	logic [RAD_WIDTH-1:0] rad_s  [1:STAGES];
	logic [RAD_WIDTH-1:0] root_s [1:STAGES];
	cmu_pkg::side_t       side_s [1:STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam logic [RAD_WIDTH-1:0] BIT = RAD_WIDTH'(1) << (2 * (STAGES - 1 - k));
		logic [RAD_WIDTH-1:0] rad_k;
		logic [RAD_WIDTH-1:0] root_k;
		cmu_pkg::side_t       side_k;
		logic [RAD_WIDTH-1:0] trial;
		logic                 fits;

		// first stage takes the module inputs, later stages the previous register
		if (k == 0) begin : g_first
			assign rad_k  = rad;
			assign root_k = '0;
			assign side_k = side;
		end else begin : g_next
			assign rad_k  = rad_s[k];
			assign root_k = root_s[k];
			assign side_k = side_s[k];
		end

		always_comb begin
			trial = root_k + BIT;
			fits  = rad_k >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k+1] <= '0;
			end else if (en) begin
				side_s[k+1] <= side_k;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (fits) begin
					rad_s[k+1]  <= rad_k - trial;
					root_s[k+1] <= (root_k >> 1) + BIT;
				end else begin
					rad_s[k+1]  <= rad_k;
					root_s[k+1] <= root_k >> 1;
				end
			end
		end
	end

	assign root     = root_s[STAGES];
	assign side_out = side_s[STAGES];

endmodule
`default_nettype wire

// ===== sv/complex_magnitude_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// complex_magnitude_unit
// Power and floor square root magnitude of a stream of complex samples.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel: real_part, imag_part, last_in with sample_valid and
//   sample_stall. Result channel: magnitude, power, last_out with
//   result_valid and result_stall. A word moves when valid is high and
//   stall is low.
//   One result word per sample word, in order; last_out copies last_in.
//   The path is registered after absolute value, square and sum, then one
//   stage per root bit in the square root pipeline, then the output register.
//   Throughput is one word per cycle; the pipeline takes a new sample every
//   cycle while results are taken.
//   Reset clears all valid bits; no word is in flight afterwards.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   sample_stall rises in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module complex_magnitude_unit #(
	parameter int SAMPLE_WIDTH = cmu_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic signed [SAMPLE_WIDTH-1:0]    real_part,
	input  wire logic signed [SAMPLE_WIDTH-1:0]    imag_part,
	input  wire logic                              last_in,
	input  wire logic                              sample_valid,
	output logic                                   sample_stall,
	output logic             [cmu_pkg::MAG_WIDTH-1:0]   magnitude,
	output logic             [cmu_pkg::POWER_WIDTH-1:0] power,
	output logic                                   last_out,
	output logic                                   result_valid,
	input  wire logic                              result_stall
);

	localparam int PW = 2 * SAMPLE_WIDTH;

	logic en;

	logic                    v_s1, v_s2, v_s3, v_s5;
	logic                    last_s1, last_s2, last_s3;
	logic [SAMPLE_WIDTH-1:0] a_s1, b_s1;
	logic [PW-1:0]           sq_a_s2, sq_b_s2;
	logic [PW-1:0]           pw_s3;
	logic [cmu_pkg::POWER_WIDTH-1:0] power_s3;

	logic [PW-1:0]           pw_sum;
	logic [63:0]             pw_wide;
	logic [PW-1:0]           root;
	logic [63:0]             root_wide;
	cmu_pkg::side_t          side_in;
	cmu_pkg::side_t          side_out;

	logic [cmu_pkg::MAG_WIDTH-1:0]   magnitude_s5;
	logic [cmu_pkg::POWER_WIDTH-1:0] power_s5;
	logic                            last_s5;

	// Advance everything unless a valid result is held by the receiver.
	assign en           = !(v_s5 && result_stall);
	assign sample_stall = !en;

	always_comb begin
		pw_sum  = sq_a_s2 + sq_b_s2;
		pw_wide = 64'(pw_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s5 <= side_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: absolute values; the most negative value maps to 2^(W-1)
			a_s1    <= real_part[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-real_part)
			                                     : SAMPLE_WIDTH'(real_part);
			b_s1    <= imag_part[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-imag_part)
			                                     : SAMPLE_WIDTH'(imag_part);
			last_s1 <= last_in;
			// stage 2: squares
			sq_a_s2 <= PW'(a_s1) * PW'(a_s1);
			sq_b_s2 <= PW'(b_s1) * PW'(b_s1);
			last_s2 <= last_s1;
			// stage 3: sum and clamp power to its field
			pw_s3    <= pw_sum;
			power_s3 <= (pw_wide[63:32] != '0) ? '1 : pw_wide[31:0];
			last_s3  <= last_s2;
		end
	end

	always_comb begin
		side_in.valid = v_s3;
		side_in.last  = last_s3;
		side_in.power = power_s3;
	end

	cmu_isqrt #(
		.RAD_WIDTH(PW)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.rad      (pw_s3),
		.side     (side_in),
		.root     (root),
		.side_out (side_out)
	);

	assign root_wide = 64'(root);

	always_ff @(posedge clk) begin
		if (en) begin
			// clamp the root to the magnitude field
			magnitude_s5 <= (root_wide[63:16] != '0) ? '1 : root_wide[15:0];
			power_s5     <= side_out.power;
			last_s5      <= side_out.last;
		end
	end

	assign result_valid = v_s5;
	assign magnitude    = magnitude_s5;
	assign power        = power_s5;
	assign last_out     = last_s5;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream test of complex_magnitude_unit: directed corner samples, then random
// arrays closed by last_in, with bursty sample traffic and patterned result
// stalls. Each result word is checked field by field against a predicted
// power, floor square root and last flag.
// ----------------------------------------------------------------------------
module tb;

	localparam int SW         = cmu_pkg::SAMPLE_WIDTH_DEF;
	localparam int MW         = cmu_pkg::MAG_WIDTH;
	localparam int PW         = cmu_pkg::POWER_WIDTH;
	localparam int LATENCY    = SW + 4;
	localparam int ARRAY_GOAL = 1750;
	localparam int CYCLE_CAP  = 200000;

	typedef struct {
		logic signed [SW-1:0] re;
		logic signed [SW-1:0] im;
		logic                 last;
		bit                   drain_first;
	} sample_word_t;

	typedef struct {
		logic [MW-1:0] magnitude;
		logic [PW-1:0] power;
		logic          last;
	} result_word_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic signed [SW-1:0] real_part    = '0;
	logic signed [SW-1:0] imag_part    = '0;
	logic                 last_in      = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 result_stall = 1'b0;
	logic                 sample_stall;
	logic [MW-1:0]        magnitude;
	logic [PW-1:0]        power;
	logic                 last_out;
	logic                 result_valid;

	sample_word_t sample_backlog[$];
	result_word_t awaited_results[$];
	int           error_count = 0;
	int           cycle_count = 0;
	bit           word_taken  = 1'b0;

	complex_magnitude_unit #(.SAMPLE_WIDTH(SW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.real_part(real_part),
		.imag_part(imag_part),
		.last_in(last_in),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.magnitude(magnitude),
		.power(power),
		.last_out(last_out),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	always #5 clk = ~clk;

	// Floor square root, one root bit per step.
	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned root;
		longint unsigned probe;
		root  = 0;
		probe = 64'd1 << 62;
		while (probe > x)
			probe = probe >> 2;
		while (probe != 0) begin
			if (x >= root + probe) begin
				x    = x - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic result_word_t power_and_root(input sample_word_t s);
		longint          re_s;
		longint          im_s;
		longint unsigned re_a;
		longint unsigned im_a;
		longint unsigned pwr;
		longint unsigned mag;
		result_word_t    r;
		re_s = s.re;
		im_s = s.im;
		re_a = (re_s < 0) ? -re_s : re_s;
		im_a = (im_s < 0) ? -im_s : im_s;
		pwr  = re_a * re_a + im_a * im_a;
		mag  = floor_sqrt(pwr);
		// saturate only matters for wide samples
		r.power     = (pwr > 64'hFFFF_FFFF) ? {PW{1'b1}} : pwr[PW-1:0];
		r.magnitude = (mag > 64'hFFFF) ? {MW{1'b1}} : mag[MW-1:0];
		r.last      = s.last;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("MISMATCH at cycle %0d: %s got %0d expected %0d",
			cycle_count, what, got, want);
		error_count++;
	endtask

	task automatic queue_sample(input logic signed [SW-1:0] re,
			input logic signed [SW-1:0] im, input logic last, input bit drain);
		sample_word_t s;
		s.re          = re;
		s.im          = im;
		s.last        = last;
		s.drain_first = drain;
		sample_backlog.push_back(s);
	endtask

	function automatic logic signed [SW-1:0] random_part();
		int unsigned pick;
		int          v;
		pick = $urandom_range(0, 19);
		if (pick < 10)
			v = $urandom();
		else if (pick < 14)
			v = int'($urandom_range(0, 16)) - 8;
		else if (pick < 17)
			v = $urandom_range(0, 1) ? (-(2 ** (SW-1)) + int'($urandom_range(0, 3)))
				: ((2 ** (SW-1)) - 1 - int'($urandom_range(0, 3)));
		else
			v = 0;
		return SW'(v);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Result checker; also records each accepted sample word.
	always @(posedge clk) begin : result_check
		result_word_t want;
		word_taken <= arst_n && sample_valid && !sample_stall;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result, power", power, 0);
				end else begin
					want = awaited_results.pop_front();
					if (magnitude !== want.magnitude)
						report_mismatch("magnitude", magnitude, want.magnitude);
					if (power !== want.power)
						report_mismatch("power", power, want.power);
					if (last_out !== want.last)
						report_mismatch("last_out", last_out, want.last);
				end
			end
			if (sample_valid && !sample_stall)
				awaited_results.push_back(power_and_root('{real_part, imag_part, last_in, 1'b0}));
		end
	end

	// Sample driver: bursts of words with random gaps between them.
	int unsigned burst_left = 1;
	int unsigned gap_left   = 0;

	always @(negedge clk) begin : sample_driver
		sample_word_t s;
		if (arst_n && !(sample_valid && !word_taken)) begin
			if (gap_left != 0) begin
				gap_left = gap_left - 1;
				sample_valid <= 1'b0;
			end else if (sample_backlog.size() == 0 ||
					(sample_backlog[0].drain_first && awaited_results.size() != 0)) begin
				sample_valid <= 1'b0;
			end else begin
				s = sample_backlog.pop_front();
				real_part    <= s.re;
				imag_part    <= s.im;
				last_in      <= s.last;
				sample_valid <= 1'b1;
				burst_left   = burst_left - 1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// Receiver stall: the pattern is redrawn after each span of random length.
	int unsigned stall_mode = 0;
	int unsigned stall_span = 0;
	int unsigned stall_tick = 0;

	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_span = $urandom_range(20, 200);
		end
		stall_span = stall_span - 1;
		stall_tick = stall_tick + 1;
		case (stall_mode)
			0: begin
				result_stall <= 1'b0;
			end
			1: begin
				result_stall <= 1'($urandom_range(0, 1));
			end
			2: begin
				result_stall <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				result_stall <= (stall_tick % 3 == 0);
			end
		endcase
	end

	initial begin : stimulus
		int unsigned total;
		int unsigned len;
		logic signed [SW-1:0] most_neg;
		logic signed [SW-1:0] most_pos;
		most_neg = SW'(-(2 ** (SW-1)));
		most_pos = SW'((2 ** (SW-1)) - 1);
		total    = 0;

		// corners: both parts most negative gives power 2^31
		queue_sample(most_neg, most_neg, 1'b0, 1'b0);
		queue_sample(most_pos, most_pos, 1'b0, 1'b0);
		queue_sample(most_neg, most_pos, 1'b1, 1'b0);
		queue_sample(most_pos, most_neg, 1'b0, 1'b0);
		queue_sample(most_neg, '0, 1'b0, 1'b0);
		queue_sample('0, most_neg, 1'b1, 1'b0);
		queue_sample(most_pos, '0, 1'b0, 1'b0);
		queue_sample('0, '0, 1'b0, 1'b0);
		queue_sample(SW'(1), SW'(0), 1'b1, 1'b0);
		queue_sample(SW'(-1), SW'(-1), 1'b0, 1'b0);
		queue_sample(SW'(3), SW'(-4), 1'b0, 1'b0);
		queue_sample(SW'(2), SW'(1), 1'b1, 1'b0);
		queue_sample(SW'(-5), SW'(12), 1'b0, 1'b0);
		queue_sample(SW'(1), SW'(1), 1'b1, 1'b0);
		queue_sample(-16'sd181, 16'sd181, 1'b0, 1'b0);
		queue_sample(16'sh5555, -16'sh2AAB, 1'b1, 1'b0);

		// random arrays, each closed by last_in
		while (total < ARRAY_GOAL) begin
			len = $urandom_range(1, 24);
			for (int unsigned i = 0; i < len; i++)
				queue_sample(random_part(), random_part(), i == len - 1,
					i == 0 && (total == 0 || (total < 900 && total + len >= 900)));
			total = total + len;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sample_backlog.size() != 0 || sample_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY + 8) @(posedge clk);
		if (awaited_results.size() != 0)
			report_mismatch("results never delivered", awaited_results.size(), 0);

		if (error_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
